### rtl/core/cdfp_pkg.sv
// package for the csv decimal field parser
// byte codes, token and result types, register indexes; no dependencies
package cdfp_pkg;

    localparam int MANT_BITS = 40;
    localparam int ROW_BITS  = 16;
    localparam int COL_BITS  = 10;
    localparam int FRAC_BITS = 4;
    localparam int CFG_IDX_BITS = 8;

    localparam logic [7:0] BYTE_NL    = 8'h0A;
    localparam logic [7:0] BYTE_POINT = 8'h2E;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;
    localparam logic [7:0] DELIM_RESET = 8'h2C;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DELIMITER   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_SKIP_HEADER = CFG_IDX_BITS'(1);

    localparam logic [MANT_BITS-1:0] MANT_MAX = '1;
    localparam logic [ROW_BITS-1:0]  ROW_MAX  = '1;
    localparam logic [COL_BITS-1:0]  COL_MAX  = '1;
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

    typedef logic [2:0] t_kind;
    localparam t_kind KIND_OTHER   = 3'd0;
    localparam t_kind KIND_DIGIT   = 3'd1;
    localparam t_kind KIND_POINT   = 3'd2;
    localparam t_kind KIND_MINUS   = 3'd3;
    localparam t_kind KIND_DELIM   = 3'd4;
    localparam t_kind KIND_NEWLINE = 3'd5;

    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
    } t_token;

    typedef struct packed {
        logic                 is_negative;
        logic [MANT_BITS-1:0] magnitude;
        logic [FRAC_BITS-1:0] fraction_digits;
        logic                 overflowed;
        logic [ROW_BITS-1:0]  row_index;
        logic [COL_BITS-1:0]  column_index;
        logic                 row_end;
    } t_result;

    typedef struct packed {
        logic pop;
        logic emit;
    } t_back_status;

endpackage

### rtl/core/cdfp_front.sv
// front end: takes text bytes, skips the header line, classifies into tokens
// holds the delimiter and header state; depends on cdfp_pkg
module cdfp_front import cdfp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [7:0]              i_text_byte,
    input  logic                    i_queue_full,
    input  logic                    i_cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    output logic                    o_push,
    output t_token                  o_token
);

    logic [7:0] r_delim, n_delim;
    logic       r_in_header, n_in_header;
    logic       w_accept;
    logic       w_is_nl;
    t_kind      w_kind;

    assign w_accept = i_in_valid && !i_queue_full;
    assign w_is_nl  = (i_text_byte == BYTE_NL);

    always_comb begin
        if (w_is_nl) begin
            w_kind = KIND_NEWLINE;
        end else if (i_text_byte == r_delim) begin
            w_kind = KIND_DELIM;
        end else if (i_text_byte >= BYTE_ZERO && i_text_byte <= BYTE_NINE) begin
            w_kind = KIND_DIGIT;
        end else if (i_text_byte == BYTE_POINT) begin
            w_kind = KIND_POINT;
        end else if (i_text_byte == BYTE_MINUS) begin
            w_kind = KIND_MINUS;
        end else begin
            w_kind = KIND_OTHER;
        end
    end

    assign o_token.kind  = w_kind;
    assign o_token.digit = i_text_byte[3:0];
    assign o_push = w_accept && !r_in_header && (w_kind != KIND_OTHER);

    always_comb begin
        n_delim     = r_delim;
        n_in_header = r_in_header;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DELIMITER:   n_delim = i_cfg_data;
                CFG_SKIP_HEADER: n_in_header = i_cfg_data[0];
                default: ;
            endcase
        end else if (w_accept && r_in_header && w_is_nl) begin
            n_in_header = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= DELIM_RESET;
            r_in_header <= 1'b0;
        end else begin
            r_delim     <= n_delim;
            r_in_header <= n_in_header;
        end
    end

endmodule

### rtl/core/cdfp_queue.sv
// two-entry token queue between front and back end
// depends on cdfp_pkg for the token type
module cdfp_queue import cdfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_token i_token,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_token
);

    t_token     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = !r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = !r_rd_ptr;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/core/cdfp_back.sv
// back end: field accumulator, row and column counters, output register
// consumes tokens from the queue; depends on cdfp_pkg
module cdfp_back import cdfp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_token       i_token,
    input  logic         i_out_stall,
    output t_back_status o_status,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic [MANT_BITS-1:0] r_acc, n_acc;
    logic [FRAC_BITS-1:0] r_frac, n_frac;
    logic                 r_point, n_point;
    logic                 r_minus, n_minus;
    logic                 r_sat, n_sat;
    logic [ROW_BITS-1:0]  r_row, n_row;
    logic [COL_BITS-1:0]  r_col, n_col;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    logic                 w_emit_tok;
    logic                 w_slot_free;
    logic                 w_pop;
    logic [MANT_BITS+3:0] w_wide;
    logic [MANT_BITS+3:0] w_next;

    assign w_emit_tok  = (i_token.kind == KIND_DELIM) || (i_token.kind == KIND_NEWLINE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_pop       = i_q_valid && (!w_emit_tok || w_slot_free);
    assign w_wide      = {4'b0, r_acc};
    assign w_next      = (w_wide << 3) + (w_wide << 1)
                         + {{MANT_BITS{1'b0}}, i_token.digit};

    assign o_status.pop  = w_pop;
    assign o_status.emit = w_pop && w_emit_tok;
    assign o_out_valid   = r_out_valid;
    assign o_result      = r_out;

    always_comb begin
        n_acc       = r_acc;
        n_frac      = r_frac;
        n_point     = r_point;
        n_minus     = r_minus;
        n_sat       = r_sat;
        n_row       = r_row;
        n_col       = r_col;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        if (w_pop) begin
            unique case (i_token.kind)
                KIND_DIGIT: begin
                    if (|w_next[MANT_BITS+3:MANT_BITS]) begin
                        n_acc = MANT_MAX;
                        n_sat = 1'b1;
                    end else begin
                        n_acc = w_next[MANT_BITS-1:0];
                    end
                    if (r_point) begin
                        if (r_frac != FRAC_MAX) begin
                            n_frac = r_frac + 1'b1;
                        end else begin
                            n_sat = 1'b1;
                        end
                    end
                end
                KIND_POINT: n_point = 1'b1;
                KIND_MINUS: n_minus = 1'b1;
                KIND_DELIM, KIND_NEWLINE: begin
                    n_out_valid         = 1'b1;
                    n_out.is_negative     = r_minus;
                    n_out.magnitude       = r_acc;
                    n_out.fraction_digits = r_frac;
                    n_out.overflowed      = r_sat;
                    n_out.row_index       = r_row;
                    n_out.column_index    = r_col;
                    n_out.row_end         = (i_token.kind == KIND_NEWLINE);
                    n_acc   = '0;
                    n_frac  = '0;
                    n_point = 1'b0;
                    n_minus = 1'b0;
                    n_sat   = 1'b0;
                    if (i_token.kind == KIND_NEWLINE) begin
                        n_col = '0;
                        if (r_row != ROW_MAX) begin
                            n_row = r_row + 1'b1;
                        end
                    end else if (r_col != COL_MAX) begin
                        n_col = r_col + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_frac      <= '0;
            r_point     <= 1'b0;
            r_minus     <= 1'b0;
            r_sat       <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_frac      <= n_frac;
            r_point     <= n_point;
            r_minus     <= n_minus;
            r_sat       <= n_sat;
            r_row       <= n_row;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/core/csv_decimal_field_parser_unit.sv
// top level of the csv decimal field parser
// connects cdfp_front, cdfp_queue and cdfp_back; depends on cdfp_pkg
//
// input channel: one text byte per beat, i_in_valid / o_in_stall.
// output channel: one parsed field per beat, o_out_valid / i_out_stall;
//   a field is emitted for each delimiter or newline byte outside a skipped header line, none otherwise.
// config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is the
//   delimiter byte, index 1 the skip-header flag; other indexes are ignored.
// throughput: one byte per cycle sustained while the receiver does not stall;
//   the multiply-by-ten and add of the field accumulator in the back end is combinational.
// path: a field-ending byte is written into the token queue, and when the back end
//   pops it the result is loaded into the output register, which drives the output.
// a two-entry token queue sits between front and back end; o_in_stall rises
//   only when it is full, which happens when the receiver stalls a result.
// reset: delimiter ',' , header skipping off, counters and field state zero,
//   queue and output register empty; no clearing pass is needed.
// while the receiver stalls, the result holds and bytes that do not end a
//   field keep flowing until the next field end reaches the back end.
module csv_decimal_field_parser_unit import cdfp_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_text_byte,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [7:0]              i_cfg_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_is_negative,
    output logic [MANT_BITS-1:0]    o_magnitude,
    output logic [FRAC_BITS-1:0]    o_fraction_digits,
    output logic                    o_overflowed,
    output logic [ROW_BITS-1:0]     o_row_index,
    output logic [COL_BITS-1:0]     o_column_index,
    output logic                    o_row_end
);

    logic         w_push;
    t_token       w_push_token;
    logic         w_q_full;
    logic         w_q_valid;
    t_token       w_q_token;
    t_back_status w_status;
    t_result      w_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_q_full;

    cdfp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_text_byte  (i_text_byte),
        .i_queue_full (w_q_full),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (w_push),
        .o_token      (w_push_token)
    );

    cdfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_token (w_push_token),
        .i_pop   (w_status.pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_token (w_q_token)
    );

    cdfp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_token     (w_q_token),
        .i_out_stall (i_out_stall),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_result    (w_result)
    );

    assign o_is_negative     = w_result.is_negative;
    assign o_magnitude       = w_result.magnitude;
    assign o_fraction_digits = w_result.fraction_digits;
    assign o_overflowed      = w_result.overflowed;
    assign o_row_index       = w_result.row_index;
    assign o_column_index    = w_result.column_index;
    assign o_row_end         = w_result.row_end;

`ifndef NO_ASSERTIONS
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> w_q_valid)
        else $error("queue full while empty");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.emit |=> o_out_valid)
        else $error("field end popped but no result");

    a_taken_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !w_status.emit) |=> !o_out_valid)
        else $error("result repeated after being taken");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.pop |-> w_q_valid)
        else $error("pop from empty queue");
`endif

endmodule
